>>> hw/rtl/lattice_boltzmann_cell_collide_defines.svh
// ----------------------------------------------------------------------------
// Lattice Boltzmann cell collision: assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LATTICE_BOLTZMANN_CELL_COLLIDE_DEFINES_SVH
`define LATTICE_BOLTZMANN_CELL_COLLIDE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LBMCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbmcc assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LBMCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbmcc assertion failed");

`endif

>>> hw/rtl/lbmcc_pkg.sv
// ----------------------------------------------------------------------------
// lbmcc_pkg
// Types, constants and fixed-point helpers for the D2Q9 BGK collision pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbmcc_pkg;

  localparam int unsigned NumDir = 9;
  localparam int unsigned WideW = 48;
  localparam int unsigned MagW = 42;
  localparam int unsigned HalfW = MagW / 2;
  localparam int unsigned PpW = MagW + HalfW;
  localparam int unsigned SumW = PpW + HalfW;
  localparam int unsigned DivBits = 31;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages = (DivBits + DivStepsPerStage - 1) / DivStepsPerStage;
  localparam int unsigned FeqStages = 4;
  localparam int unsigned RelaxStages = 5;

  localparam logic [30:0] RelaxRateReset = 31'd2101633718;

  typedef logic signed [WideW-1:0] wide_t;

  localparam wide_t QOne = 48'sd1073741824;
  localparam wide_t RoundHalf = 48'sd536870912;
  localparam wide_t SatMax = 48'sd2147483647;
  localparam wide_t SatMin = -48'sd2147483648;

  localparam logic signed [1:0] DirX [NumDir] =
    '{2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] DirY [NumDir] =
    '{2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0, -2'sd1};
  localparam wide_t Weight [NumDir] =
    '{48'sd29826162, 48'sd119304647, 48'sd29826162, 48'sd119304647, 48'sd477218588,
      48'sd119304647, 48'sd29826162, 48'sd119304647, 48'sd29826162};

  typedef struct packed {
    logic                     solid;
    logic [NumDir-1:0][31:0]  pop;
  } cell_t;

  typedef struct packed {
    cell_t              item;
    logic signed [31:0] rho;
    logic signed [34:0] mx;
    logic signed [34:0] my;
  } sum_t;

  typedef struct packed {
    cell_t              item;
    logic signed [31:0] rho;
    logic               rho_pos;
    logic               neg_x;
    logic               neg_y;
    logic               sat_x;
    logic               sat_y;
    logic [32:0]        rem_x;
    logic [32:0]        rem_y;
    logic [30:0]        quo_x;
    logic [30:0]        quo_y;
  } div_t;

  typedef struct packed {
    logic           neg;
    logic [PpW-1:0] lo;
    logic [PpW-1:0] hi;
  } mulq_pp_t;

  typedef struct packed {
    cell_t                       item;
    logic signed [31:0]          rho;
    logic signed [31:0]          ux;
    logic signed [31:0]          uy;
    logic [NumDir-1:0][WideW-1:0] cu;
    logic [NumDir-1:0][WideW-1:0] a;
    logic [NumDir-1:0][WideW-1:0] b;
    wide_t                       uu;
    wide_t                       vv;
    mulq_pp_t [NumDir-1:0]       pp_a;
    mulq_pp_t [NumDir-1:0]       pp_b;
    mulq_pp_t                    pp_uu;
    mulq_pp_t                    pp_vv;
  } fq_t;

  typedef struct packed {
    cell_t                        item;
    logic signed [31:0]           rho;
    logic signed [31:0]           ux;
    logic signed [31:0]           uy;
    logic [NumDir-1:0][WideW-1:0] val;
    mulq_pp_t [NumDir-1:0]        pp;
  } rlx_t;

  typedef struct packed {
    logic [NumDir-1:0][31:0] post;
    logic signed [31:0]      rho;
    logic signed [31:0]      ux;
    logic signed [31:0]      uy;
  } out_t;

  function automatic logic [MagW-1:0] mag_w(wide_t v);
    wide_t m;
    m = (v < 0) ? -v : v;
    return m[MagW-1:0];
  endfunction

  // First half of a rounded Q30 product: magnitudes and two partial products.
  function automatic mulq_pp_t mulq_pp(wide_t a, wide_t b);
    logic [MagW-1:0] ua;
    logic [MagW-1:0] ub;
    mulq_pp_t r;
    ua = mag_w(a);
    ub = mag_w(b);
    r.neg = (a < 0) != (b < 0);
    r.lo = {{HalfW{1'b0}}, ua} * {{MagW{1'b0}}, ub[HalfW-1:0]};
    r.hi = {{HalfW{1'b0}}, ua} * {{MagW{1'b0}}, ub[MagW-1:HalfW]};
    return r;
  endfunction

  // Second half: sum, round half away from zero, restore the sign.
  function automatic wide_t mulq_fin(mulq_pp_t p);
    logic [SumW-1:0] s;
    logic [SumW-31:0] m;
    wide_t r;
    s = {p.hi, {HalfW{1'b0}}} + {{HalfW{1'b0}}, p.lo} + SumW'(RoundHalf);
    m = s[SumW-1:30];
    r = $signed(m[WideW-1:0]);
    return p.neg ? -r : r;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    wide_t r;
    if (v > SatMax) begin
      r = SatMax;
    end else if (v < SatMin) begin
      r = SatMin;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] vel_of(logic pos, logic neg, logic sat,
                                                logic [30:0] quo);
    logic signed [31:0] r;
    if (!pos) begin
      r = '0;
    end else if (sat) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lbmcc_moments.sv
// ----------------------------------------------------------------------------
// lbmcc_moments
// Density and momentum sums, then divider set-up, over two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbmcc_moments (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  lbmcc_pkg::cell_t    cell_i,
  output logic                valid_o,
  output lbmcc_pkg::div_t     div_o
);
  import lbmcc_pkg::*;

  sum_t s1_d, s1_q;
  div_t s2_d, s2_q;
  logic s1_valid_q, s2_valid_q;

  always_comb begin
    logic signed [35:0] acc;
    logic signed [34:0] mx;
    logic signed [34:0] my;
    logic signed [34:0] p;
    acc = '0;
    mx = '0;
    my = '0;
    for (int k = 0; k < NumDir; k++) begin
      p = 35'($signed(cell_i.pop[k]));
      acc = acc + 36'(p);
      if (DirX[k] > 0) mx = mx + p;
      if (DirX[k] < 0) mx = mx - p;
      if (DirY[k] > 0) my = my + p;
      if (DirY[k] < 0) my = my - p;
    end
    s1_d.item = cell_i;
    s1_d.mx = mx;
    s1_d.my = my;
    if (acc > 36'sd2147483647) begin
      s1_d.rho = 32'sh7FFF_FFFF;
    end else if (acc < -36'sd2147483648) begin
      s1_d.rho = 32'sh8000_0000;
    end else begin
      s1_d.rho = acc[31:0];
    end
  end

  always_comb begin
    logic [34:0] umx;
    logic [34:0] umy;
    logic [33:0] twice;
    umx = (s1_q.mx < 0) ? 35'(-s1_q.mx) : 35'(s1_q.mx);
    umy = (s1_q.my < 0) ? 35'(-s1_q.my) : 35'(s1_q.my);
    twice = {1'b0, s1_q.rho[31:0], 1'b0};
    s2_d.item = s1_q.item;
    s2_d.rho = s1_q.rho;
    s2_d.rho_pos = s1_q.rho > 0;
    s2_d.neg_x = s1_q.mx < 0;
    s2_d.neg_y = s1_q.my < 0;
    s2_d.sat_x = umx[33:0] >= twice;
    s2_d.sat_y = umy[33:0] >= twice;
    s2_d.rem_x = umx[32:0];
    s2_d.rem_y = umy[32:0];
    s2_d.quo_x = '0;
    s2_d.quo_y = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign div_o = s2_q;

endmodule

`default_nettype wire

>>> hw/rtl/lbmcc_vdiv.sv
// ----------------------------------------------------------------------------
// lbmcc_vdiv
// Pipelined restoring divider for both velocity components, a few quotient
// bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbmcc_vdiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  lbmcc_pkg::div_t  div_i,
  output logic             valid_o,
  output lbmcc_pkg::div_t  div_o
);
  import lbmcc_pkg::*;

  div_t st_d [DivStages];
  div_t st_q [DivStages];
  logic [DivStages-1:0] valid_q;

  always_comb begin
    div_t t;
    logic [32:0] dv;
    logic ge;
    for (int s = 0; s < DivStages; s++) begin
      t = (s == 0) ? div_i : st_q[(s == 0) ? 0 : s - 1];
      dv = {2'b00, t.rho[30:0]};
      for (int b = 0; b < DivStepsPerStage; b++) begin
        if (s * DivStepsPerStage + b < DivBits) begin
          ge = t.rem_x >= dv;
          t.rem_x = ge ? t.rem_x - dv : t.rem_x;
          t.rem_x = {t.rem_x[31:0], 1'b0};
          t.quo_x = {t.quo_x[29:0], ge};
          ge = t.rem_y >= dv;
          t.rem_y = ge ? t.rem_y - dv : t.rem_y;
          t.rem_y = {t.rem_y[31:0], 1'b0};
          t.quo_y = {t.quo_y[29:0], ge};
        end
      end
      st_d[s] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[DivStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign div_o = st_q[DivStages-1];

endmodule

`default_nettype wire

>>> hw/rtl/lbmcc_feq.sv
// ----------------------------------------------------------------------------
// lbmcc_feq
// Velocity saturation, projected velocities, squares and density weights,
// and the equilibrium bracket terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbmcc_feq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  lbmcc_pkg::div_t  div_i,
  output logic             valid_o,
  output lbmcc_pkg::fq_t   fq_o
);
  import lbmcc_pkg::*;

  fq_t st_d [FeqStages];
  fq_t st_q [FeqStages];
  logic [FeqStages-1:0] valid_q;

  always_comb begin
    fq_t t;
    wide_t usqr;
    t = st_q[0];
    t.item = div_i.item;
    t.rho = div_i.rho;
    t.ux = vel_of(div_i.rho_pos, div_i.neg_x, div_i.sat_x, div_i.quo_x);
    t.uy = vel_of(div_i.rho_pos, div_i.neg_y, div_i.sat_y, div_i.quo_y);
    for (int k = 0; k < NumDir; k++) begin
      t.cu[k] = 3 * (wide_t'(DirX[k]) * wide_t'(t.ux) + wide_t'(DirY[k]) * wide_t'(t.uy));
    end
    st_d[0] = t;

    t = st_q[0];
    t.pp_uu = mulq_pp(wide_t'(st_q[0].ux), wide_t'(st_q[0].ux));
    t.pp_vv = mulq_pp(wide_t'(st_q[0].uy), wide_t'(st_q[0].uy));
    for (int k = 0; k < NumDir; k++) begin
      t.pp_a[k] = mulq_pp(wide_t'(st_q[0].rho), Weight[k]);
      t.pp_b[k] = mulq_pp($signed(st_q[0].cu[k]), $signed(st_q[0].cu[k]));
    end
    st_d[1] = t;

    t = st_q[1];
    t.uu = mulq_fin(st_q[1].pp_uu);
    t.vv = mulq_fin(st_q[1].pp_vv);
    for (int k = 0; k < NumDir; k++) begin
      t.a[k] = mulq_fin(st_q[1].pp_a[k]);
      t.b[k] = mulq_fin(st_q[1].pp_b[k]);
    end
    st_d[2] = t;

    t = st_q[2];
    usqr = (3 * (st_q[2].uu + st_q[2].vv) + 48'sd1) >>> 1;
    for (int k = 0; k < NumDir; k++) begin
      t.b[k] = QOne + $signed(st_q[2].cu[k]) + (($signed(st_q[2].b[k]) + 48'sd1) >>> 1) - usqr;
    end
    st_d[3] = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[FeqStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q[FeqStages-1];
  assign fq_o = st_q[FeqStages-1];

endmodule

`default_nettype wire

>>> hw/rtl/lbmcc_relax.sv
// ----------------------------------------------------------------------------
// lbmcc_relax
// Equilibrium products, BGK relaxation by omega, saturation and bounce-back,
// ending in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbmcc_relax (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  lbmcc_pkg::fq_t   fq_i,
  input  logic [30:0]      relax_rate_i,
  output logic             valid_o,
  output lbmcc_pkg::out_t  out_o
);
  import lbmcc_pkg::*;

  rlx_t st_d [RelaxStages];
  rlx_t st_q [RelaxStages];
  logic [RelaxStages-1:0] valid_q;
  out_t out_d, out_q;
  logic out_valid_q;

  always_comb begin
    rlx_t t;
    wide_t omega;
    omega = {17'b0, relax_rate_i};

    t = st_q[0];
    t.item = fq_i.item;
    t.rho = fq_i.rho;
    t.ux = fq_i.ux;
    t.uy = fq_i.uy;
    for (int k = 0; k < NumDir; k++) begin
      t.pp[k] = mulq_pp($signed(fq_i.a[k]), $signed(fq_i.b[k]));
    end
    st_d[0] = t;

    t = st_q[0];
    for (int k = 0; k < NumDir; k++) begin
      t.val[k] = mulq_fin(st_q[0].pp[k]);
    end
    st_d[1] = t;

    t = st_q[1];
    for (int k = 0; k < NumDir; k++) begin
      t.val[k] = wide_t'($signed(st_q[1].item.pop[k])) - $signed(st_q[1].val[k]);
    end
    st_d[2] = t;

    t = st_q[2];
    for (int k = 0; k < NumDir; k++) begin
      t.pp[k] = mulq_pp(omega, $signed(st_q[2].val[k]));
    end
    st_d[3] = t;

    t = st_q[3];
    for (int k = 0; k < NumDir; k++) begin
      t.val[k] = mulq_fin(st_q[3].pp[k]);
    end
    st_d[4] = t;

    out_d.rho = st_q[4].rho;
    out_d.ux = st_q[4].ux;
    out_d.uy = st_q[4].uy;
    for (int k = 0; k < NumDir; k++) begin
      if (st_q[4].item.solid) begin
        out_d.post[k] = st_q[4].item.pop[NumDir-1-k];
      end else begin
        out_d.post[k] = sat32(wide_t'($signed(st_q[4].item.pop[k])) - $signed(st_q[4].val[k]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= {valid_q[RelaxStages-2:0], valid_i};
      out_valid_q <= valid_q[RelaxStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/lattice_boltzmann_cell_collide.sv
// ----------------------------------------------------------------------------
// lattice_boltzmann_cell_collide
// D2Q9 BGK collision of one lattice cell per transaction, signed Q2.30.
// ----------------------------------------------------------------------------
// The block accepts one cell per clock while the output side does not stall.
// The path is a single pipeline with one shared advance: 2 stages of sums and
// divider set-up, 8 stages of a restoring divider that forms up to four
// velocity quotient bits per stage, 4 stages of equilibrium terms and 6 stages
// of relaxation ending in the output register. A stall on the output holds
// every stage, so the input is ready whenever the output register is empty or
// being taken. The relax_rate register is written through its own channel,
// which is always ready, and should change only while no cell is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "lattice_boltzmann_cell_collide_defines.svh"

module lattice_boltzmann_cell_collide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_relax_rate_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pop_0_i,
  input  logic signed [31:0] pop_1_i,
  input  logic signed [31:0] pop_2_i,
  input  logic signed [31:0] pop_3_i,
  input  logic signed [31:0] pop_4_i,
  input  logic signed [31:0] pop_5_i,
  input  logic signed [31:0] pop_6_i,
  input  logic signed [31:0] pop_7_i,
  input  logic signed [31:0] pop_8_i,
  input  logic               is_solid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] post_0_o,
  output logic signed [31:0] post_1_o,
  output logic signed [31:0] post_2_o,
  output logic signed [31:0] post_3_o,
  output logic signed [31:0] post_4_o,
  output logic signed [31:0] post_5_o,
  output logic signed [31:0] post_6_o,
  output logic signed [31:0] post_7_o,
  output logic signed [31:0] post_8_o,
  output logic signed [31:0] density_o,
  output logic signed [31:0] velocity_x_o,
  output logic signed [31:0] velocity_y_o
);
  import lbmcc_pkg::*;

  logic [30:0] relax_rate_q;
  logic adv;
  cell_t cell_in;
  logic mom_valid, div_valid, feq_valid;
  div_t mom_div, div_res;
  fq_t fq;
  out_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_rate_q <= RelaxRateReset;
    end else if (cfg_valid_i) begin
      relax_rate_q <= cfg_relax_rate_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign cell_in.solid = is_solid_i;
  assign cell_in.pop = {pop_8_i, pop_7_i, pop_6_i, pop_5_i, pop_4_i,
                        pop_3_i, pop_2_i, pop_1_i, pop_0_i};

  lbmcc_moments u_moments (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .cell_i  (cell_in),
    .valid_o (mom_valid),
    .div_o   (mom_div)
  );

  lbmcc_vdiv u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (mom_valid),
    .div_i   (mom_div),
    .valid_o (div_valid),
    .div_o   (div_res)
  );

  lbmcc_feq u_feq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid),
    .div_i   (div_res),
    .valid_o (feq_valid),
    .fq_o    (fq)
  );

  lbmcc_relax u_relax (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (feq_valid),
    .fq_i         (fq),
    .relax_rate_i (relax_rate_q),
    .valid_o      (out_valid_o),
    .out_o        (res)
  );

  assign post_0_o = res.post[0];
  assign post_1_o = res.post[1];
  assign post_2_o = res.post[2];
  assign post_3_o = res.post[3];
  assign post_4_o = res.post[4];
  assign post_5_o = res.post[5];
  assign post_6_o = res.post[6];
  assign post_7_o = res.post[7];
  assign post_8_o = res.post[8];
  assign density_o = res.rho;
  assign velocity_x_o = res.ux;
  assign velocity_y_o = res.uy;

  // A cell without positive density carries no velocity.
  `LBMCC_ASSERT_IMP(a_zero_velocity, out_valid_o && density_o <= 0,
                    velocity_x_o == 0 && velocity_y_o == 0)

  // The pipe only refuses input while a finished result waits.
  `LBMCC_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

  // A configuration transaction lands in the register on the next cycle.
  `LBMCC_ASSERT_NEXT(a_cfg_write, cfg_valid_i && cfg_ready_o,
                     relax_rate_q == $past(cfg_relax_rate_i))

endmodule

`default_nettype wire
